>>> hdl/lph_pkg.sv
package lph_pkg;

    localparam int TABLE_SLOTS = 256;
    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int LOAD_MAX = (TABLE_SLOTS * 3) / 4;
    localparam logic [29:0] HASH_MASK = 30'h3fffffff;

    typedef enum logic [1:0] {
        K_GET  = 2'd0,
        K_SET  = 2'd1,
        K_DEL  = 2'd2,
        K_NEXT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_END       = 3'd3,
        ST_NIL       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_USED  = 2'd1,
        TAG_TOMB  = 2'd2
    } tag_t;

    typedef enum logic [1:0] {
        CL_IMM   = 2'd0,
        CL_SCAN  = 2'd1,
        CL_PROBE = 2'd2
    } cls_t;

    typedef enum logic [2:0] {
        BS_IDLE = 3'd0,
        BS_RD   = 3'd1,
        BS_CHK  = 3'd2,
        BS_SRD  = 3'd3,
        BS_SCHK = 3'd4
    } back_state_t;

    typedef struct packed {
        kind_t             kind;
        cls_t              cls;
        status_t           imm_status;
        logic [63:0]       key;
        logic [63:0]       value;
        logic [IDX_W-1:0]  start;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } q_ctl_t;

endpackage

>>> hdl/linear_probe_hash_table.sv
// Flow: a request passes the front stage register and the command queue; one that needs
// no probe is answered from idle, a probe reads and checks each slot in turn, and next
// scans slots the same way. The probe engine takes one request at a time, and only once
// the previous result has been taken; slot reads share the single memory read port.
// Reset: asynchronous; all slots read as empty at once through per-slot valid bits.
module linear_probe_hash_table
    import lph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic        key_absent,
    input  logic [63:0] key,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [63:0] out_key,
    output logic [63:0] out_value
);

    q_ctl_t q_ctl;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    cmd_t   push_cmd;
    cmd_t   head_cmd;

    assign q_ctl.push = q_push;
    assign q_ctl.pop = q_pop;
    assign q_ctl.full = q_full;
    assign q_ctl.empty = q_empty;

    lph_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .key_absent (key_absent),
        .key        (key),
        .value      (value),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    lph_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    lph_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_in      (q_ctl),
        .q_head    (head_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .out_key   (out_key),
        .out_value (out_value)
    );

endmodule

>>> hdl/lph_front.sv
module lph_front
    import lph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic        key_absent,
    input  logic [63:0] key,
    input  logic [63:0] value,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic        s1_vld_reg;
    logic        s1_vld_next;
    cmd_t        s1_cmd_reg;
    logic [63:0] s1_h_reg;
    logic [63:0] ha, hb, hc, hd, he, hf;
    logic [29:0] h30;
    cmd_t        cmd_in;
    logic        accept;

    // First half of the key mix, taken on the input beat.
    always_comb
    begin
        ha = ~key + (key << 18);
        hb = ha ^ (ha >> 31);
        hc = (hb << 4) + (hb << 2) + hb;
    end

    always_comb
    begin
        cmd_in = '0;
        cmd_in.kind = kind_t'(kind);
        cmd_in.key = key;
        cmd_in.value = value;
        cmd_in.imm_status = ST_OK;
        cmd_in.cls = CL_PROBE;
        if (key_absent)
        begin
            case (kind_t'(kind))
                K_SET:
                begin
                    cmd_in.cls = CL_IMM;
                    cmd_in.imm_status = ST_NIL;
                end
                K_NEXT:
                begin
                    cmd_in.cls = CL_SCAN;
                end
                default:
                begin
                    cmd_in.cls = CL_IMM;
                    cmd_in.imm_status = ST_NOT_FOUND;
                end
            endcase
        end
    end

    assign q_push = s1_vld_reg && !q_full;
    assign in_ready = !s1_vld_reg || !q_full;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (accept)
        begin
            s1_vld_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= cmd_in;
            s1_h_reg <= hc;
        end
    end

    // Second half of the mix gives the start slot.
    always_comb
    begin
        hd = s1_h_reg ^ (s1_h_reg >> 11);
        he = hd + (hd << 6);
        hf = he ^ (he >> 22);
        h30 = hf[29:0] & HASH_MASK;
        q_cmd = s1_cmd_reg;
        q_cmd.start = h30[IDX_W-1:0];
    end

endmodule

>>> hdl/lph_queue.sv
module lph_queue
    import lph_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  cmd_t   push_cmd,
    input  logic   pop,
    output cmd_t   head,
    output logic   full,
    output logic   empty
);

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign head = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hdl/lph_back.sv
module lph_back
    import lph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_ctl_t      q_in,
    input  cmd_t        q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [63:0] out_key,
    output logic [63:0] out_value
);

    logic [63:0] key_mem [TABLE_SLOTS];
    logic [63:0] val_mem [TABLE_SLOTS];
    logic [1:0]  tag_mem [TABLE_SLOTS];

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] tomb_reg, tomb_next;
    logic             have_tomb_reg, have_tomb_next;
    logic [IDX_W:0]   scan_reg, scan_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [TABLE_SLOTS-1:0] vld_reg, vld_next;
    logic        out_vld_reg, out_vld_next;
    status_t     res_status_reg;
    logic [63:0] res_key_reg, res_value_reg;

    logic [63:0] key_q, val_q;
    logic [1:0]  tag_q;
    logic        vld_q;
    tag_t        tag;

    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic        rd_en, wr_key_en, wr_val_en, wr_tag_en;
    tag_t        wr_tag;
    logic        res_load;
    status_t     res_status;
    logic [63:0] res_key, res_value;
    logic        start_cmd;

    logic hit, is_empty, is_tomb, last, eff_have, free_ok;
    logic [IDX_W-1:0] eff_tomb, free_slot;

    assign tag = vld_q ? tag_t'(tag_q) : TAG_EMPTY;
    assign hit = (tag == TAG_USED) && (key_q == cmd_reg.key);
    assign is_empty = (tag == TAG_EMPTY);
    assign is_tomb = (tag == TAG_TOMB);
    assign last = &n_reg;
    assign eff_have = have_tomb_reg || is_tomb;
    assign eff_tomb = have_tomb_reg ? tomb_reg : idx_reg;
    assign free_ok = is_empty || eff_have;
    assign free_slot = eff_have ? eff_tomb : idx_reg;
    assign start_cmd = (state_reg == BS_IDLE) && !q_in.empty && !out_vld_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE:
            begin
                if (start_cmd)
                begin
                    case (q_head.cls)
                        CL_SCAN:
                        begin
                            state_next = BS_SRD;
                        end
                        CL_PROBE:
                        begin
                            if ((count_reg != '0) || (q_head.kind == K_SET))
                            begin
                                state_next = BS_RD;
                            end
                        end
                        default:
                        begin
                            state_next = BS_IDLE;
                        end
                    endcase
                end
            end
            BS_RD:
            begin
                state_next = BS_CHK;
            end
            BS_CHK:
            begin
                if (hit && (cmd_reg.kind == K_NEXT))
                begin
                    state_next = BS_SRD;
                end
                else if (hit || is_empty || last)
                begin
                    state_next = BS_IDLE;
                end
                else
                begin
                    state_next = BS_RD;
                end
            end
            BS_SRD:
            begin
                state_next = scan_reg[IDX_W] ? BS_IDLE : BS_SCHK;
            end
            BS_SCHK:
            begin
                state_next = (tag == TAG_USED) ? BS_IDLE : BS_SRD;
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop = start_cmd;
        cmd_next = cmd_reg;
        idx_next = idx_reg;
        n_next = n_reg;
        tomb_next = tomb_reg;
        have_tomb_next = have_tomb_reg;
        scan_next = scan_reg;
        count_next = count_reg;
        vld_next = vld_reg;
        rd_en = 1'b0;
        rd_addr = idx_reg;
        wr_addr = idx_reg;
        wr_key_en = 1'b0;
        wr_val_en = 1'b0;
        wr_tag_en = 1'b0;
        wr_tag = TAG_USED;
        res_load = 1'b0;
        res_status = ST_OK;
        res_key = '0;
        res_value = '0;
        case (state_reg)
            BS_IDLE:
            begin
                if (start_cmd)
                begin
                    cmd_next = q_head;
                    idx_next = q_head.start;
                    n_next = '0;
                    have_tomb_next = 1'b0;
                    scan_next = '0;
                    if (q_head.cls == CL_IMM)
                    begin
                        res_load = 1'b1;
                        res_status = q_head.imm_status;
                    end
                    else if ((q_head.cls == CL_PROBE) && (count_reg == '0)
                             && (q_head.kind != K_SET))
                    begin
                        res_load = 1'b1;
                        res_status = ST_NOT_FOUND;
                    end
                end
            end
            BS_RD:
            begin
                rd_en = 1'b1;
                rd_addr = idx_reg;
            end
            BS_CHK:
            begin
                if (hit)
                begin
                    case (cmd_reg.kind)
                        K_GET:
                        begin
                            res_load = 1'b1;
                            res_value = val_q;
                        end
                        K_SET:
                        begin
                            res_load = 1'b1;
                            wr_val_en = 1'b1;
                        end
                        K_DEL:
                        begin
                            res_load = 1'b1;
                            wr_tag_en = 1'b1;
                            wr_tag = TAG_TOMB;
                            count_next = count_reg - CNT_W'(1);
                            if (count_reg == CNT_W'(1))
                            begin
                                vld_next = '0;
                            end
                        end
                        default:
                        begin
                            scan_next = {1'b0, idx_reg} + (IDX_W+1)'(1);
                        end
                    endcase
                end
                else if (is_empty || last)
                begin
                    res_load = 1'b1;
                    res_status = ST_NOT_FOUND;
                    if (cmd_reg.kind == K_SET)
                    begin
                        if ((count_reg >= CNT_W'(LOAD_MAX)) || !free_ok)
                        begin
                            res_status = ST_FULL;
                        end
                        else
                        begin
                            res_status = ST_OK;
                            wr_addr = free_slot;
                            wr_key_en = 1'b1;
                            wr_val_en = 1'b1;
                            wr_tag_en = 1'b1;
                            wr_tag = TAG_USED;
                            vld_next[free_slot] = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    n_next = n_reg + IDX_W'(1);
                    if (is_tomb && !have_tomb_reg)
                    begin
                        have_tomb_next = 1'b1;
                        tomb_next = idx_reg;
                    end
                end
            end
            BS_SRD:
            begin
                rd_addr = scan_reg[IDX_W-1:0];
                if (scan_reg[IDX_W])
                begin
                    res_load = 1'b1;
                    res_status = ST_END;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            BS_SCHK:
            begin
                if (tag == TAG_USED)
                begin
                    res_load = 1'b1;
                    res_key = key_q;
                    res_value = val_q;
                end
                else
                begin
                    scan_next = scan_reg + (IDX_W+1)'(1);
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (res_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
            count_reg <= '0;
            vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            vld_reg <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        n_reg <= n_next;
        tomb_reg <= tomb_next;
        have_tomb_reg <= have_tomb_next;
        scan_reg <= scan_next;
        if (res_load)
        begin
            res_status_reg <= res_status;
            res_key_reg <= res_key;
            res_value_reg <= res_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            key_q <= key_mem[rd_addr];
            val_q <= val_mem[rd_addr];
            tag_q <= tag_mem[rd_addr];
            vld_q <= vld_reg[rd_addr];
        end
        if (wr_key_en)
        begin
            key_mem[wr_addr] <= cmd_reg.key;
        end
        if (wr_val_en)
        begin
            val_mem[wr_addr] <= cmd_reg.value;
        end
        if (wr_tag_en)
        begin
            tag_mem[wr_addr] <= wr_tag;
        end
    end

    assign out_valid = out_vld_reg;
    assign status = res_status_reg;
    assign out_key = res_key_reg;
    assign out_value = res_value_reg;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !out_vld_reg)
        else $error("result loaded while previous result pending");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LOAD_MAX))
        else $error("entry count above load limit");
    a_empty_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (vld_reg == '0))
        else $error("slots marked valid in an empty table");
    a_rd_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_RD) |=> (state_reg == BS_CHK))
        else $error("probe read not followed by check");
`endif

endmodule
